@@ hw/rtl/anchor_free_detection_decode_macros.svh @@
// Assertion helpers shared by the decode RTL.
// Both expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ANCHOR_FREE_DETECTION_DECODE_MACROS_SVH
`define ANCHOR_FREE_DETECTION_DECODE_MACROS_SVH

// Same-cycle implication.
`define AFDD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AFDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/afdd_pkg.sv @@
package afdd_pkg;

	localparam int LOGIT_W  = 16;
	localparam int CLS_W    = 4;
	localparam int CELL_W   = 8;
	localparam int SEL_W    = 2;
	localparam int SH_W     = 3;
	localparam int EDGE_W   = 18;
	localparam int SIZE_W   = 17;
	localparam int SCORE_W  = 16;
	localparam int CENTER_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int MAX_CLASSES_DEF = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OBJ_THR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd2;

	localparam logic [SCORE_W-1:0] OBJ_THR_RST   = 16'd1311;
	localparam logic [SCORE_W-1:0] SCORE_THR_RST = 16'd1311;
	localparam logic [CLS_W-1:0]   TARGET_RST    = 4'd3;

	localparam logic [17:0] LOG2E_Q16 = 18'd94548;
	localparam logic [15:0] SIG_LIMIT = 16'd2048;

	localparam logic [15:0] SIG_TAB [17] = '{
		16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565,
		16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097, 16'd65269,
		16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
	};

	localparam logic [17:0] POW2_TAB [17] = '{
		18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
		18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
		18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
	};

	// advance enables of the shared pipeline stages
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} afdd_adv_t;

	// Q8.8 logit to Q0.16 probability, table with linear interpolation
	function automatic logic [SCORE_W-1:0] afdd_sigmoid(input logic signed [LOGIT_W-1:0] x);
		logic [15:0] a;
		logic [3:0]  i;
		logic [6:0]  f;
		logic [12:0] d;
		logic [19:0] prod;
		logic [15:0] p;
		a = x[15] ? 16'(-x) : 16'(x);
		i = a[10:7];
		f = a[6:0];
		d = 13'(SIG_TAB[5'(i) + 5'd1] - SIG_TAB[5'(i)]);
		prod = 20'(d) * 20'(f) + 20'd64;
		if (a >= SIG_LIMIT)
			p = SIG_TAB[16];
		else
			p = SIG_TAB[5'(i)] + 16'(prod >> 7);
		return x[15] ? 16'(17'h10000 - 17'(p)) : p;
	endfunction

	// center minus half size, floored to Q13.4 and saturated
	function automatic logic [EDGE_W-1:0] afdd_edge(input logic signed [CENTER_W-1:0] c8,
			input logic [SIZE_W-1:0] size);
		logic signed [24:0] e8;
		logic signed [20:0] e4;
		e8 = 25'(c8) - 25'({size, 3'b000});
		e4 = e8[24:4];
		if (e4 > 21'sd131071)
			return 18'h1FFFF;
		else if (e4 < -21'sd131072)
			return 18'h20000;
		else
			return e4[17:0];
	endfunction

endpackage

@@ hw/rtl/afdd_class_if.sv @@
interface afdd_class_if import afdd_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [LOGIT_W-1:0] class_logit;
	logic                      class_last;
	logic signed [LOGIT_W-1:0] obj_logit;
	logic signed [LOGIT_W-1:0] offset_x;
	logic signed [LOGIT_W-1:0] offset_y;
	logic signed [LOGIT_W-1:0] log_width;
	logic signed [LOGIT_W-1:0] log_height;
	logic [CELL_W-1:0]         cell_x;
	logic [CELL_W-1:0]         cell_y;
	logic [SEL_W-1:0]          stride_sel;

	modport source (output valid, class_logit, class_last, obj_logit, offset_x, offset_y,
		log_width, log_height, cell_x, cell_y, stride_sel, input ready);
	modport sink (input valid, class_logit, class_last, obj_logit, offset_x, offset_y,
		log_width, log_height, cell_x, cell_y, stride_sel, output ready);
endinterface

@@ hw/rtl/afdd_box_if.sv @@
interface afdd_box_if import afdd_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [EDGE_W-1:0] box_left;
	logic signed [EDGE_W-1:0] box_top;
	logic [SIZE_W-1:0]        box_width;
	logic [SIZE_W-1:0]        box_height;
	logic [SCORE_W-1:0]       box_score;

	modport source (output valid, box_left, box_top, box_width, box_height, box_score,
		input ready);
	modport sink (input valid, box_left, box_top, box_width, box_height, box_score,
		output ready);
endinterface

@@ hw/rtl/afdd_argmax.sv @@
module afdd_argmax import afdd_pkg::*; #(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      take,
	input  logic signed [LOGIT_W-1:0] logit,
	input  logic                      last,
	output logic signed [LOGIT_W-1:0] fin_logit,
	output logic [CLS_W-1:0]          fin_class
);

	logic signed [LOGIT_W-1:0] best_logit_q;
	logic [CLS_W-1:0]          best_class_q;
	logic [CLS_W-1:0]          class_counter_q;
	logic                      taken_q;
	logic                      full_q;
	logic                      upd;

	// strict greater-than: the first class keeps a tie
	assign upd       = !full_q && (!taken_q || (logit > best_logit_q));
	assign fin_logit = upd ? logit : best_logit_q;
	assign fin_class = upd ? class_counter_q : best_class_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_logit_q    <= '0;
			best_class_q    <= '0;
			class_counter_q <= '0;
			taken_q         <= 1'b0;
			full_q          <= 1'b0;
		end else if (take) begin
			if (last) begin
				best_logit_q    <= '0;
				best_class_q    <= '0;
				class_counter_q <= '0;
				taken_q         <= 1'b0;
				full_q          <= 1'b0;
			end else if (!full_q) begin
				best_logit_q <= fin_logit;
				best_class_q <= fin_class;
				taken_q      <= 1'b1;
				if (class_counter_q >= CLS_W'(MAX_CLASSES - 1))
					full_q <= 1'b1;
				else
					class_counter_q <= class_counter_q + 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/afdd_size.sv @@
module afdd_size import afdd_pkg::*; (
	input  logic                      clk,
	input  afdd_adv_t                 adv,
	input  logic signed [LOGIT_W-1:0] log_size_s1,
	input  logic [SH_W-1:0]           sh_s1,
	output logic [SIZE_W-1:0]         size_s4
);

	logic signed [33:0] y_s2;
	logic [SH_W-1:0]    sh_s2;
	logic [17:0]        m_s3;
	logic signed [10:0] k_s3;

	logic [3:0]         idx;
	logic [19:0]        fr;
	logic [12:0]        dlt;
	logic [32:0]        prod;
	logic [17:0]        m;
	logic signed [10:0] k;
	logic [4:0]         s;
	logic [20:0]        t;
	logic [SIZE_W-1:0]  r;

	// exponent split: n = floor(y / 2^24), 2^frac from the table
	always_comb begin
		idx  = y_s2[23:20];
		fr   = y_s2[19:0];
		dlt  = 13'(POW2_TAB[5'(idx) + 5'd1] - POW2_TAB[5'(idx)]);
		prod = 33'(dlt) * 33'(fr) + 33'd524288;
		m    = POW2_TAB[5'(idx)] + 18'(prod >> 20);
		k    = 11'($signed(y_s2[33:24])) + 11'(sh_s2) - 11'sd12;
	end

	// scale by 2^k into Q13.4, round half up, saturate
	always_comb begin
		s = '0;
		t = '0;
		if (k_s3 > 11'sd0)
			r = '1;
		else if (k_s3 == 11'sd0)
			r = (m_s3 > 18'd131071) ? '1 : m_s3[SIZE_W-1:0];
		else if (k_s3 < -11'sd20)
			r = '0;
		else begin
			s = 5'(-k_s3);
			t = 21'(m_s3) + (21'd1 << (s - 5'd1));
			r = SIZE_W'(t >> s);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			y_s2  <= 34'(log_size_s1) * 34'($signed(LOG2E_Q16));
			sh_s2 <= sh_s1;
		end
		if (adv.s3) begin
			m_s3 <= m;
			k_s3 <= k;
		end
		if (adv.s4)
			size_s4 <= r;
	end

endmodule

@@ hw/rtl/anchor_free_detection_decode.sv @@
// Anchor-free box decode for one target class.
//
// logits (sink): one transaction per class logit. The anchor fields (objectness,
// offsets, log sizes, cell, stride select) are sampled only on the transaction
// with class_last set, which closes the anchor.
// boxes (source): at most one transaction per anchor, sent when the argmax class
// equals target_class, sigmoid(objectness) reaches objectness_threshold and the
// product score reaches score_threshold.
// cfg_wr_en/cfg_index/cfg_wr_data: register writes, taken at any clock edge with
// cfg_wr_en high; write only while no anchor is in flight.
//
// The box leaves on boxes after its closing logit is accepted and passes the
// four register stages and the output register. Throughput is one logit per cycle
// while boxes does not back up the pipeline; the exp and sigmoid units are fully pipelined.
// Reset clears the running argmax, all stage valids and loads the register
// defaults. When boxes stalls, transactions queue in the stage registers; logits
// drops ready only once every stage and the output register hold data.
`include "anchor_free_detection_decode_macros.svh"

module anchor_free_detection_decode import afdd_pkg::*; #(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	afdd_class_if.sink            logits,
	afdd_box_if.source            boxes,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

	// configuration
	logic [SCORE_W-1:0] obj_thr_q;
	logic [SCORE_W-1:0] score_thr_q;
	logic [CLS_W-1:0]   target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_thr_q   <= OBJ_THR_RST;
			score_thr_q <= SCORE_THR_RST;
			target_q    <= TARGET_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_OBJ_THR:   obj_thr_q   <= cfg_wr_data[SCORE_W-1:0];
				CFG_SCORE_THR: score_thr_q <= cfg_wr_data[SCORE_W-1:0];
				CFG_TARGET:    target_q    <= cfg_wr_data[CLS_W-1:0];
				default: ;
			endcase
		end
	end

	// stage control: each stage moves when it is empty or the next one moves
	logic      valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic      rdy1, rdy2, rdy3, rdy4, rdy_o;
	logic      accept;
	afdd_adv_t adv;

	assign rdy_o  = !out_valid_q || boxes.ready;
	assign rdy4   = !valid_s4 || rdy_o;
	assign rdy3   = !valid_s3 || rdy4;
	assign rdy2   = !valid_s2 || rdy3;
	assign rdy1   = !valid_s1 || rdy2;
	assign adv    = '{s2: rdy2, s3: rdy3, s4: rdy4};
	assign accept = logits.valid && rdy1;

	assign logits.ready = rdy1;

	// running argmax over the current anchor
	logic signed [LOGIT_W-1:0] fin_logit;
	logic [CLS_W-1:0]          fin_class;

	afdd_argmax #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_argmax (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (accept),
		.logit     (logits.class_logit),
		.last      (logits.class_last),
		.fin_logit (fin_logit),
		.fin_class (fin_class)
	);

	// stage 1: closing transaction of an anchor
	logic signed [LOGIT_W-1:0] cls_logit_s1, obj_logit_s1;
	logic signed [LOGIT_W-1:0] offx_s1, offy_s1, logw_s1, logh_s1;
	logic [CLS_W-1:0]          cls_class_s1;
	logic [CELL_W-1:0]         cellx_s1, celly_s1;
	logic [SH_W-1:0]           sh_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			cls_logit_s1 <= fin_logit;
			cls_class_s1 <= fin_class;
			obj_logit_s1 <= logits.obj_logit;
			offx_s1      <= logits.offset_x;
			offy_s1      <= logits.offset_y;
			logw_s1      <= logits.log_width;
			logh_s1      <= logits.log_height;
			cellx_s1     <= logits.cell_x;
			celly_s1     <= logits.cell_y;
			// the reserved select acts as stride 32
			sh_s1        <= (logits.stride_sel == 2'd3) ? 3'd5 : 3'd3 + 3'(logits.stride_sel);
		end
	end

	// stage 2: sigmoids, class match, centers in Q.8 pixels
	logic [SCORE_W-1:0]         sig_cls_s2, sig_obj_s2;
	logic                       keep_s2;
	logic signed [CENTER_W-1:0] cx8_s2, cy8_s2;
	logic signed [17:0]         sum_x, sum_y;

	assign sum_x = 18'(offx_s1) + 18'({cellx_s1, 8'b0});
	assign sum_y = 18'(offy_s1) + 18'({celly_s1, 8'b0});

	always_ff @(posedge clk) begin
		if (rdy2) begin
			sig_cls_s2 <= afdd_sigmoid(cls_logit_s1);
			sig_obj_s2 <= afdd_sigmoid(obj_logit_s1);
			keep_s2    <= (cls_class_s1 == target_q);
			cx8_s2     <= CENTER_W'(sum_x) << sh_s1;
			cy8_s2     <= CENTER_W'(sum_y) << sh_s1;
		end
	end

	// stage 3: product score, objectness test
	logic [SCORE_W-1:0]         score_s3;
	logic                       keep_s3;
	logic signed [CENTER_W-1:0] cx8_s3, cy8_s3;
	logic [31:0]                score_full;

	assign score_full = 32'(sig_cls_s2) * 32'(sig_obj_s2) + 32'd32768;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			score_s3 <= score_full[31:16];
			keep_s3  <= keep_s2 && (sig_obj_s2 >= obj_thr_q);
			cx8_s3   <= cx8_s2;
			cy8_s3   <= cy8_s2;
		end
	end

	// stage 4: score test; sizes come out of the exp units here
	logic [SCORE_W-1:0]         score_s4;
	logic                       keep_s4;
	logic signed [CENTER_W-1:0] cx8_s4, cy8_s4;
	logic [SIZE_W-1:0]          w_s4, h_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			score_s4 <= score_s3;
			keep_s4  <= keep_s3 && (score_s3 >= score_thr_q);
			cx8_s4   <= cx8_s3;
			cy8_s4   <= cy8_s3;
		end
	end

	afdd_size u_size_w (
		.clk         (clk),
		.adv         (adv),
		.log_size_s1 (logw_s1),
		.sh_s1       (sh_s1),
		.size_s4     (w_s4)
	);

	afdd_size u_size_h (
		.clk         (clk),
		.adv         (adv),
		.log_size_s1 (logh_s1),
		.sh_s1       (sh_s1),
		.size_s4     (h_s4)
	);

	// stage valids; an anchor that fails a test is dropped at the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1)
				valid_s1 <= accept && logits.class_last;
			if (rdy2)
				valid_s2 <= valid_s1;
			if (rdy3)
				valid_s3 <= valid_s2;
			if (rdy4)
				valid_s4 <= valid_s3;
			if (rdy_o)
				out_valid_q <= valid_s4 && keep_s4;
		end
	end

	// output register: edges from center and saturated size
	logic [EDGE_W-1:0]  left_q, top_q;
	logic [SIZE_W-1:0]  width_q, height_q;
	logic [SCORE_W-1:0] score_q;

	always_ff @(posedge clk) begin
		if (rdy_o) begin
			left_q   <= afdd_edge(cx8_s4, w_s4);
			top_q    <= afdd_edge(cy8_s4, h_s4);
			width_q  <= w_s4;
			height_q <= h_s4;
			score_q  <= score_s4;
		end
	end

	assign boxes.valid      = out_valid_q;
	assign boxes.box_left   = left_q;
	assign boxes.box_top    = top_q;
	assign boxes.box_width  = width_q;
	assign boxes.box_height = height_q;
	assign boxes.box_score  = score_q;

	`AFDD_ASSERT_NOW(a_stall_full, !logits.ready,
		valid_s1 && valid_s2 && valid_s3 && valid_s4 && out_valid_q && !boxes.ready,
		"logits stalled while a stage was free")
	`AFDD_ASSERT_NEXT(a_last_loads, accept && logits.class_last, valid_s1,
		"closing transaction did not enter stage 1")
	`AFDD_ASSERT_NOW(a_box_source, $rose(out_valid_q), $past(valid_s4 && keep_s4),
		"box appeared without a passing stage 4 entry")

endmodule

@@ test/anchor_free_detection_decode_tb.sv @@
`timescale 1ns / 1ps

module anchor_free_detection_decode_tb;
	import afdd_pkg::*;

	localparam int SETTLE_CYCLES   = 12;   // drain margin after the last box, covers the pipeline depth
	localparam int HOLD_OFF_CYCLES = 300;  // long receiver stall for the back-pressure phase
	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int REPORT_LIMIT    = 10;

	// One logit transaction as it sits on the class channel.
	typedef struct {
		logic signed [LOGIT_W-1:0] class_logit;
		logic                      class_last;
		logic signed [LOGIT_W-1:0] obj_logit;
		logic signed [LOGIT_W-1:0] offset_x;
		logic signed [LOGIT_W-1:0] offset_y;
		logic signed [LOGIT_W-1:0] log_width;
		logic signed [LOGIT_W-1:0] log_height;
		logic [CELL_W-1:0]         cell_x;
		logic [CELL_W-1:0]         cell_y;
		logic [SEL_W-1:0]          stride_sel;
	} logit_beat_t;

	// One decoded box as it leaves the block.
	typedef struct {
		logic signed [EDGE_W-1:0] left;
		logic signed [EDGE_W-1:0] top;
		logic [SIZE_W-1:0]        width;
		logic [SIZE_W-1:0]        height;
		logic [SCORE_W-1:0]       score;
	} decoded_box_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wr_data;

	afdd_class_if logits ();
	afdd_box_if   boxes ();

	anchor_free_detection_decode dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.logits      (logits),
		.boxes       (boxes),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	// Lookup tables of the decode arithmetic: sigmoid over |x| in half steps,
	// and 2^f for f in sixteenths, Q2.16.
	int sig_lut [17] = '{
		32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
		64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514
	};
	longint pow2_lut [17] = '{
		65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752, 92682,
		96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072
	};

	// Register copies and running argmax of the prediction.
	logic [SCORE_W-1:0]        obj_thr_cfg   = OBJ_THR_RST;
	logic [SCORE_W-1:0]        score_thr_cfg = SCORE_THR_RST;
	logic [CLS_W-1:0]          target_cfg    = TARGET_RST;
	logic signed [LOGIT_W-1:0] arg_logit = '0;
	logic [CLS_W-1:0]          arg_class = '0;
	int                        arg_count = 0;
	bit                        arg_taken = 1'b0;
	bit                        arg_full  = 1'b0;

	logit_beat_t  pending_logits [$];
	decoded_box_t expected_boxes [$];
	logit_beat_t  held_beat;

	int logits_queued   = 0;
	int logits_accepted = 0;
	int anchors_queued  = 0;
	int boxes_checked   = 0;
	int mismatch_count  = 0;
	int settings_used   = 1;
	int send_idle_pct   = 0;
	int recv_idle_pct   = 0;
	logic hold_req      = 1'b0;
	int quiet_cycles    = 0;

	// Q8.8 logit to Q0.16 probability.
	function automatic logic [SCORE_W-1:0] sigmoid_q16(input logic signed [LOGIT_W-1:0] x);
		int a;
		int i;
		int p;
		a = (x < 0) ? -int'(x) : int'(x);
		if (a >= 2048) begin
			p = sig_lut[16];
		end else begin
			i = a >> 7;
			p = sig_lut[i] + (((sig_lut[i+1] - sig_lut[i]) * (a & 127) + 64) >> 7);
		end
		return (x < 0) ? SCORE_W'(65536 - p) : SCORE_W'(p);
	endfunction

	// exp(x) times the stride, Q13.4, saturated.
	function automatic logic [SIZE_W-1:0] exp_size_q4(input logic signed [LOGIT_W-1:0] x,
			input int sh);
		longint yb;
		longint n;
		longint frac;
		longint idx;
		longint m;
		longint k;
		longint r;
		yb = longint'(x) * 94548 + (longint'(1) << 32);
		n = (yb >> 24) - 256;
		frac = yb & 64'hFF_FFFF;
		idx = frac >> 20;
		m = pow2_lut[idx] + (((pow2_lut[idx+1] - pow2_lut[idx]) * (frac & 64'hF_FFFF)
			+ (longint'(1) << 19)) >> 20);
		k = n + sh - 12;
		if (k > 0)
			r = 131071;
		else if (k == 0)
			r = (m > 131071) ? 131071 : m;
		else if (-k > 20)
			r = 0;
		else
			r = (m + (longint'(1) << (-k - 1))) >> (-k);
		return SIZE_W'(r);
	endfunction

	// Center in Q.8 minus half the size, floored to Q13.4 and clamped.
	function automatic logic signed [EDGE_W-1:0] edge_q4(input longint c8,
			input logic [SIZE_W-1:0] size);
		longint e4;
		e4 = (c8 - longint'(size) * 8) >>> 4;
		if (e4 > 131071)
			e4 = 131071;
		if (e4 < -131072)
			e4 = -131072;
		return EDGE_W'(e4);
	endfunction

	// Advance the argmax by one logit; on the closing logit decide on a box.
	function automatic bit decode_logit(input logit_beat_t beat, output decoded_box_t box);
		logic [CLS_W-1:0]          cls;
		logic signed [LOGIT_W-1:0] cls_logit;
		logic [SCORE_W-1:0]        sig_obj;
		longint                    score;
		int                        sh;
		longint                    stride;
		box = '{default: '0};
		if (!arg_full) begin
			if (!arg_taken || beat.class_logit > arg_logit) begin
				arg_logit = beat.class_logit;
				arg_class = CLS_W'(arg_count);
			end
			arg_taken = 1'b1;
			if (arg_count >= MAX_CLASSES_DEF - 1)
				arg_full = 1'b1;
			else
				arg_count++;
		end
		if (!beat.class_last)
			return 1'b0;
		cls = arg_class;
		cls_logit = arg_logit;
		sig_obj = sigmoid_q16(beat.obj_logit);
		score = (longint'(sigmoid_q16(cls_logit)) * longint'(sig_obj) + 32768) >> 16;
		// the anchor closes whether or not a box comes out
		arg_logit = '0;
		arg_class = '0;
		arg_count = 0;
		arg_taken = 1'b0;
		arg_full  = 1'b0;
		if (cls != target_cfg || sig_obj < obj_thr_cfg || score < longint'(score_thr_cfg))
			return 1'b0;
		// the reserved select behaves as stride 32
		sh = 3 + ((beat.stride_sel > 2) ? 2 : int'(beat.stride_sel));
		stride = longint'(1) << sh;
		box.width  = exp_size_q4(beat.log_width, sh);
		box.height = exp_size_q4(beat.log_height, sh);
		box.left = edge_q4((longint'(beat.offset_x) + longint'(beat.cell_x) * 256) * stride,
			box.width);
		box.top  = edge_q4((longint'(beat.offset_y) + longint'(beat.cell_y) * 256) * stride,
			box.height);
		box.score = SCORE_W'(score);
		return 1'b1;
	endfunction

	// Place a transaction on the class channel.
	task automatic put_logit(input logit_beat_t beat);
		logits.class_logit <= beat.class_logit;
		logits.class_last  <= beat.class_last;
		logits.obj_logit   <= beat.obj_logit;
		logits.offset_x    <= beat.offset_x;
		logits.offset_y    <= beat.offset_y;
		logits.log_width   <= beat.log_width;
		logits.log_height  <= beat.log_height;
		logits.cell_x      <= beat.cell_x;
		logits.cell_y      <= beat.cell_y;
		logits.stride_sel  <= beat.stride_sel;
	endtask

	// Driver: offer the next pending logit, idling at the current rate.
	always @(posedge clk or negedge arst_n) begin
		logit_beat_t  next_beat;
		decoded_box_t box;
		if (!arst_n) begin
			logits.valid <= 1'b0;
			put_logit('{default: '0});
		end else begin
			if (logits.valid && logits.ready) begin
				// accepted: predict now, the box trails by the pipeline depth
				if (decode_logit(held_beat, box))
					expected_boxes.insert(expected_boxes.size(), box);
				logits_accepted++;
			end
			if (!logits.valid || logits.ready) begin
				if (pending_logits.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					next_beat = pending_logits.pop_front();
					held_beat = next_beat;
					put_logit(next_beat);
					logits.valid <= 1'b1;
				end else begin
					logits.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when asked for.
	always @(posedge clk or negedge arst_n) begin
		int hold_left;
		bit hold_done;
		if (!arst_n) begin
			boxes.ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_OFF_CYCLES;
			boxes.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			boxes.ready <= 1'b0;
		end else begin
			boxes.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: compare each box transaction with the oldest prediction.
	always @(posedge clk) begin
		decoded_box_t got;
		decoded_box_t want;
		if (arst_n && boxes.valid && boxes.ready) begin
			got.left   = boxes.box_left;
			got.top    = boxes.box_top;
			got.width  = boxes.box_width;
			got.height = boxes.box_height;
			got.score  = boxes.box_score;
			if (expected_boxes.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: box with none predicted: left %0d top %0d w %0d h %0d score %0d",
						$realtime, got.left, got.top, got.width, got.height, got.score);
			end else begin
				want = expected_boxes.pop_front();
				if (got.left !== want.left || got.top !== want.top || got.width !== want.width
						|| got.height !== want.height || got.score !== want.score) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%0t: box %0d mismatch", $realtime, boxes_checked);
						$display("  expected left %0d top %0d w %0d h %0d score %0d",
							want.left, want.top, want.width, want.height, want.score);
						$display("  actual   left %0d top %0d w %0d h %0d score %0d",
							got.left, got.top, got.width, got.height, got.score);
					end
				end
			end
			boxes_checked++;
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (logits.valid && logits.ready) || (boxes.valid && boxes.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic signed [LOGIT_W-1:0] pick_q88(input int lo, input int hi);
		return LOGIT_W'(int'($urandom_range(hi - lo)) + lo);
	endfunction

	// Mostly a plausible value, now and then any 16-bit pattern.
	function automatic logic signed [LOGIT_W-1:0] pick_field(input int lo, input int hi);
		return ($urandom_range(3) == 0) ? LOGIT_W'($urandom) : pick_q88(lo, hi);
	endfunction

	// Queue a logit that does not close its anchor; the anchor fields are noise.
	task automatic add_logit(input logic signed [LOGIT_W-1:0] logit);
		logit_beat_t beat;
		beat.class_logit = logit;
		beat.class_last  = 1'b0;
		beat.obj_logit   = LOGIT_W'($urandom);
		beat.offset_x    = LOGIT_W'($urandom);
		beat.offset_y    = LOGIT_W'($urandom);
		beat.log_width   = LOGIT_W'($urandom);
		beat.log_height  = LOGIT_W'($urandom);
		beat.cell_x      = CELL_W'($urandom);
		beat.cell_y      = CELL_W'($urandom);
		beat.stride_sel  = SEL_W'($urandom);
		pending_logits.insert(pending_logits.size(), beat);
		logits_queued++;
	endtask

	// Queue the closing logit of an anchor with its box fields.
	task automatic add_closing(input logic signed [LOGIT_W-1:0] logit,
			input logic signed [LOGIT_W-1:0] obj, input logic signed [LOGIT_W-1:0] ox,
			input logic signed [LOGIT_W-1:0] oy, input logic signed [LOGIT_W-1:0] lw,
			input logic signed [LOGIT_W-1:0] lh, input int cx, input int cy, input int sel);
		logit_beat_t beat;
		beat.class_logit = logit;
		beat.class_last  = 1'b1;
		beat.obj_logit   = obj;
		beat.offset_x    = ox;
		beat.offset_y    = oy;
		beat.log_width   = lw;
		beat.log_height  = lh;
		beat.cell_x      = CELL_W'(cx);
		beat.cell_y      = CELL_W'(cy);
		beat.stride_sel  = SEL_W'(sel);
		pending_logits.insert(pending_logits.size(), beat);
		logits_queued++;
		anchors_queued++;
	endtask

	// Most anchors are built so the target class wins; the rest are raw noise.
	// Some anchors run past the class limit.
	task automatic queue_random_anchor(output int n_cls);
		int tgt;
		bit hit;
		logic signed [LOGIT_W-1:0] top;
		logic signed [LOGIT_W-1:0] lg;
		tgt = int'(target_cfg);
		n_cls = ($urandom_range(9) == 0) ? int'($urandom_range(20, 17))
			: int'($urandom_range(16, 1));
		hit = ($urandom_range(99) < 70);
		if (hit && n_cls <= tgt)
			n_cls = tgt + 1 + int'($urandom_range(2));
		top = pick_q88(-512, 2047);
		for (int c = 0; c < n_cls; c++) begin
			if (!hit || c >= MAX_CLASSES_DEF)
				lg = LOGIT_W'($urandom);
			else if (c == tgt)
				lg = top;
			else if (c > tgt && $urandom_range(7) == 0)
				lg = top;  // tie after the winner, the earlier class must hold
			else
				lg = pick_q88(-32768, int'(top) - 1);
			if (c < n_cls - 1)
				add_logit(lg);
			else
				add_closing(lg, pick_field(-1024, 2047), pick_field(-256, 511),
					pick_field(-256, 511), pick_field(-1536, 1024), pick_field(-1536, 1024),
					$urandom_range(255), $urandom_range(255), $urandom_range(3));
		end
	endtask

	// Wait until every queued logit is taken and every box is back, then let
	// the pipeline drain anchors that made no box.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (logits_accepted != logits_queued || expected_boxes.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		case (idx)
			CFG_OBJ_THR:   obj_thr_cfg   = SCORE_W'(value);
			CFG_SCORE_THR: score_thr_cfg = SCORE_W'(value);
			CFG_TARGET:    target_cfg    = CLS_W'(value);
			default: ;
		endcase
	endtask

	// One register setting, one idling profile, a batch of random anchors.
	task automatic run_phase(input int obj_thr, input int score_thr, input int target,
			input int send_pct, input int recv_pct, input int n_logits, input bit hold_off);
		int queued;
		int n_cls;
		write_reg(CFG_OBJ_THR, obj_thr);
		write_reg(CFG_SCORE_THR, score_thr);
		write_reg(CFG_TARGET, target);
		settings_used++;
		send_idle_pct <= send_pct;
		recv_idle_pct <= recv_pct;
		queued = 0;
		while (queued < n_logits) begin
			queue_random_anchor(n_cls);
			queued += n_cls;
		end
		// stall the box side long enough to back the pipeline up into the input
		if (hold_off)
			hold_req <= 1'b1;
		wait_idle();
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_index   <= '0;
		cfg_wr_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed anchors under the reset registers (target class 3).
		// Single-logit anchor at the positive extremes, objectness negative: class 0 wins, no box.
		add_closing(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
			128, 128, 1);
		// Class 3 and 4 tie, the first wins; zero width at the negative extreme.
		add_logit(16'sh8000);
		add_logit(16'sh0000);
		add_logit(16'sh0000);
		add_logit(16'sd1000);
		add_closing(16'sd1000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh0000, 0, 0, 0);
		// Seventeen logits: the last one is past the limit and must not win.
		// Reserved stride select, width overflow, top edge overflow.
		for (int c = 0; c < MAX_CLASSES_DEF; c++)
			add_logit((c == 3) ? 16'sd2000 : -16'sd100);
		add_closing(16'sh7FFF, 16'sd1024, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
			255, 255, 3);
		send_idle_pct <= 16;
		recv_idle_pct <= 83;
		wait_idle();

		// Random phases: threshold and target extremes across three idling profiles.
		run_phase(0, 0, 0, 16, 83, 180, 1'b0);
		run_phase(1311, 13107, 15, 16, 83, 180, 1'b0);
		run_phase(65535, 65535, 7, 83, 16, 100, 1'b0);
		run_phase(20000, 30000, 9, 83, 16, 200, 1'b0);
		run_phase(0, 0, 5, 0, 0, 220, 1'b1);
		run_phase(1311, 1311, 3, 0, 0, 220, 1'b0);

		$display("run: %0d logits in %0d anchors, %0d boxes compared, %0d register settings",
			logits_accepted, anchors_queued, boxes_checked, settings_used);
		$display("run: random idling on both channels and one %0d-cycle box stall",
			HOLD_OFF_CYCLES);
		if (expected_boxes.size() != 0)
			$display("%0d predicted boxes never arrived", expected_boxes.size());
		if (mismatch_count == 0 && expected_boxes.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
